FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define CPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define CPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/cpc_pkg.sv
// Shared types, codes and constants of the crash peak classifier.
// No dependencies; imported by every module of the block.
package cpc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_W            = 15;
    localparam int FRAC_BITS        = 8;
    localparam int EMERG_G          = 22;
    localparam int EMERGENCY_LIMIT  = EMERG_G << FRAC_BITS;

    localparam logic [CFG_W-1:0] MARGIN_RST    = 15'd1280;
    localparam logic [CFG_W-1:0] BAND_LOW_RST  = 15'd2304;
    localparam logic [CFG_W-1:0] BAND_HIGH_RST = 15'd2714;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_READ   = 2'd1,
        REQ_START  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef enum logic [1:0] {
        CFG_MARGIN    = 2'd0,
        CFG_BAND_LOW  = 2'd1,
        CFG_BAND_HIGH = 2'd2,
        CFG_SPARE     = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SIDE_NONE  = 3'd0,
        SIDE_LEFT  = 3'd1,
        SIDE_RIGHT = 3'd2,
        SIDE_FRONT = 3'd3,
        SIDE_REAR  = 3'd4
    } side_t;

    localparam logic KIND_ALARM = 1'b0;
    localparam logic KIND_READ  = 1'b1;
    localparam logic LEVEL_PROBABLE  = 1'b0;
    localparam logic LEVEL_EMERGENCY = 1'b1;

    typedef struct packed {
        logic  fire;
        req_t  req;
        axis_t axis;
    } cpc_op_t;

    typedef struct packed {
        logic [CFG_W-1:0] margin;
        logic [CFG_W-1:0] band_low;
        logic [CFG_W-1:0] band_high;
    } cpc_cfg_t;

    typedef struct packed {
        logic  hit;
        logic  level;
        side_t side;
        logic  probable;
    } cpc_alarm_t;

endpackage

FILE: sv/cpc_peak_bank.sv
// Per-axis peak trackers and last-sample store, with read-and-clear.
// Depends on cpc_pkg.
module cpc_peak_bank import cpc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cpc_op_t                        op,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_y,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_z,
    output logic        [SAMPLE_WIDTH:0]   mag_y,
    output logic        [SAMPLE_WIDTH:0]   mag_z,
    output logic                           neg_y,
    output logic                           neg_z,
    output logic signed [SAMPLE_WIDTH-1:0] read_value
);

    localparam int W = SAMPLE_WIDTH;

    logic signed [W-1:0] peak_reg [3];
    logic signed [W-1:0] last_reg [3];
    logic signed [W-1:0] smp      [3];
    logic signed [W-1:0] track    [3];
    logic                axis_ok;
    logic [1:0]          sel;

    // exact magnitude, one bit wider so the most negative value fits
    function automatic logic [W:0] magf(logic signed [W-1:0] s);
        logic [W:0] e;
        e = {s[W-1], s};
        return s[W-1] ? -e : e;
    endfunction

    assign smp[0] = sample_x;
    assign smp[1] = sample_y;
    assign smp[2] = sample_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            track[k] = (magf(smp[k]) > magf(peak_reg[k])) ? smp[k] : peak_reg[k];
        end
    end

    assign mag_y = magf(track[1]);
    assign mag_z = magf(track[2]);
    assign neg_y = track[1][W-1];
    assign neg_z = track[2][W-1];

    assign axis_ok = (op.axis != AXIS_NONE);
    assign sel     = axis_ok ? op.axis : AXIS_X;

    always_comb begin
        if (!axis_ok) begin
            read_value = '0;
        end else if (peak_reg[sel] == '0) begin
            read_value = last_reg[sel];
        end else begin
            read_value = peak_reg[sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                peak_reg[k] <= '0;
                last_reg[k] <= '0;
            end
        end else if (op.fire && op.req == REQ_SAMPLE) begin
            for (int k = 0; k < 3; k++) begin
                peak_reg[k] <= track[k];
                last_reg[k] <= smp[k];
            end
        end else if (op.fire && op.req == REQ_READ && axis_ok) begin
            peak_reg[sel] <= '0;
        end
    end

endmodule

FILE: sv/cpc_classify.sv
// Gravity-band and emergency tests on the Y/Z peaks, plus the side and
// probable-mark state. Depends on cpc_pkg.
module cpc_classify import cpc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cpc_op_t               op,
    input  cpc_cfg_t              cfg,
    input  logic [SAMPLE_WIDTH:0] mag_y,
    input  logic [SAMPLE_WIDTH:0] mag_z,
    input  logic                  neg_y,
    input  logic                  neg_z,
    output cpc_alarm_t            alarm
);

    localparam int CW = (SAMPLE_WIDTH + 1 > CFG_W) ? SAMPLE_WIDTH + 1 : CFG_W;

    side_t         side_reg, side_next;
    logic          probable_reg, probable_next;
    logic [CW-1:0] my, mz, lim, mrg;
    logic          g1, g2, both_min, any_lim, prob_hit, side_clr;

    function automatic logic in_band(logic [CW-1:0] v, cpc_cfg_t c);
        return (v >= CW'(c.band_low)) && (v <= CW'(c.band_high));
    endfunction

    // ||p| - margin| equals the magnitude of the margin-reduced peak
    function automatic logic [CW-1:0] reduced(logic [CW-1:0] v, logic [CW-1:0] m);
        logic [CW:0] d;
        d = {1'b0, v} - {1'b0, m};
        return d[CW] ? CW'(-d) : d[CW-1:0];
    endfunction

    assign my  = CW'(mag_y);
    assign mz  = CW'(mag_z);
    assign lim = CW'(EMERGENCY_LIMIT);
    assign mrg = CW'(cfg.margin);

    always_comb begin
        g1       = in_band(reduced(my, mrg), cfg) || in_band(reduced(mz, mrg), cfg);
        g2       = in_band(my, cfg) || in_band(mz, cfg);
        both_min = (my >= mrg) && (mz >= mrg);
        any_lim  = (my >= lim) || (mz >= lim);
        prob_hit = g1 || (g2 && both_min && !any_lim);
    end

    always_comb begin
        side_next = side_reg;
        side_clr  = 1'b0;
        if (my > mz) begin
            side_next = neg_y ? SIDE_RIGHT : SIDE_LEFT;
            side_clr  = 1'b1;
        end else if (my < mz) begin
            side_next = neg_z ? SIDE_REAR : SIDE_FRONT;
            side_clr  = 1'b1;
        end
        probable_next = prob_hit ? 1'b1 : (side_clr ? 1'b0 : probable_reg);
    end

    always_comb begin
        alarm.hit      = prob_hit || any_lim;
        alarm.level    = prob_hit ? LEVEL_PROBABLE : LEVEL_EMERGENCY;
        alarm.side     = side_next;
        alarm.probable = probable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg     <= SIDE_NONE;
            probable_reg <= 1'b0;
        end else if (op.fire && op.req == REQ_START) begin
            side_reg     <= SIDE_NONE;
            probable_reg <= 1'b0;
        end else if (op.fire && op.req == REQ_SAMPLE && alarm.hit) begin
            side_reg     <= side_next;
            probable_reg <= probable_next;
        end
    end

endmodule

FILE: sv/crash_peak_classifier.sv
// Crash peak classifier: top level with input stage, config registers, result register.
// Depends on cpc_pkg, cpc_peak_bank and cpc_classify.
//
// Usage:
//  s_ channel (valid/ready) carries one request: a three-axis Q8.8 sample,
//  a read-and-clear of one axis peak, or a start that clears side and mark.
//  m_ channel (valid/ready) returns an alarm report after a sample that trips
//  a test, or the peak/last-sample value after a read. Starts, quiet samples
//  and unused request codes give no result.
//  cfg_ channel writes alarm_margin (0), g_band_low (1), g_band_high (2);
//  other indexes are dropped. cfg_ready is always high; write only when idle.
//  Path: a request accepted into the input register has its result written to
//  the output register when that register is free to take it.
//  Throughput: one request per cycle unless the output stalls; the peak compare,
//  band tests and side decision sit in one stage between input and result registers.
//  Stall: while m_ready is low and a result waits, the input register still
//  takes one more request; s_ready falls only when both registers are full.
//  Reset (aresetn low, synchronous): peaks, last samples, side and mark clear,
//  registers return to 1280 / 2304 / 2714, both channels empty.
module crash_peak_classifier import cpc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [1:0]                     s_axis,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_y,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_resp_kind,
    output logic                           m_alarm_level,
    output logic [2:0]                     m_side_code,
    output logic                           m_probable_mark,
    output logic signed [SAMPLE_WIDTH-1:0] m_read_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);

    localparam int W = SAMPLE_WIDTH;

    logic                in_valid_reg, in_valid_next;
    logic [1:0]          req_reg, axis_reg;
    logic signed [W-1:0] sx_reg, sy_reg, sz_reg;
    logic                m_valid_reg, m_valid_next;
    logic                kind_reg, level_reg, prob_reg;
    logic [2:0]          side_reg;
    logic signed [W-1:0] rd_reg;
    cpc_cfg_t            cfg_reg;
    cpc_op_t             op;
    cpc_alarm_t          alarm;
    logic [W:0]          mag_y, mag_z;
    logic                neg_y, neg_z;
    logic signed [W-1:0] bank_rd;
    logic                out_free, s_take, produce;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign op.fire = in_valid_reg && out_free;
    assign op.req  = req_t'(req_reg);
    assign op.axis = axis_t'(axis_reg);

    assign produce = op.fire &&
        ((op.req == REQ_SAMPLE && alarm.hit) || op.req == REQ_READ);

    cpc_peak_bank #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .sample_x   (sx_reg),
        .sample_y   (sy_reg),
        .sample_z   (sz_reg),
        .mag_y      (mag_y),
        .mag_z      (mag_z),
        .neg_y      (neg_y),
        .neg_z      (neg_z),
        .read_value (bank_rd)
    );

    cpc_classify #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_class (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .cfg     (cfg_reg),
        .mag_y   (mag_y),
        .mag_z   (mag_z),
        .neg_y   (neg_y),
        .neg_z   (neg_z),
        .alarm   (alarm)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (op.fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.margin    <= MARGIN_RST;
            cfg_reg.band_low  <= BAND_LOW_RST;
            cfg_reg.band_high <= BAND_HIGH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MARGIN:    cfg_reg.margin    <= cfg_data;
                CFG_BAND_LOW:  cfg_reg.band_low  <= cfg_data;
                CFG_BAND_HIGH: cfg_reg.band_high <= cfg_data;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            req_reg  <= s_req_type;
            axis_reg <= s_axis;
            sx_reg   <= s_sample_x;
            sy_reg   <= s_sample_y;
            sz_reg   <= s_sample_z;
        end
        if (produce) begin
            if (op.req == REQ_READ) begin
                kind_reg  <= KIND_READ;
                level_reg <= LEVEL_PROBABLE;
                side_reg  <= SIDE_NONE;
                prob_reg  <= 1'b0;
                rd_reg    <= bank_rd;
            end else begin
                kind_reg  <= KIND_ALARM;
                level_reg <= alarm.level;
                side_reg  <= alarm.side;
                prob_reg  <= alarm.probable;
                rd_reg    <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_resp_kind     = kind_reg;
    assign m_alarm_level   = level_reg;
    assign m_side_code     = side_reg;
    assign m_probable_mark = prob_reg;
    assign m_read_value    = rd_reg;

endmodule

FILE: sv/cpc_checker.sv
// Port-level checks for crash_peak_classifier, bound to the top level.
// Depends on cpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpc_checker import cpc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_resp_kind,
    input logic                           m_alarm_level,
    input logic [2:0]                     m_side_code,
    input logic                           m_probable_mark,
    input logic signed [SAMPLE_WIDTH-1:0] m_read_value
);

    localparam int PW = SAMPLE_WIDTH + 6;

    logic [PW-1:0] m_payload;
    logic          stall_out, read_out, alarm_out, prob_out, read_fields_clear;

    assign m_payload = {m_resp_kind, m_alarm_level, m_side_code, m_probable_mark,
                        m_read_value};
    assign stall_out = m_valid && !m_ready;
    assign read_out  = m_valid && (m_resp_kind == KIND_READ);
    assign alarm_out = m_valid && (m_resp_kind == KIND_ALARM);
    assign prob_out  = alarm_out && (m_alarm_level == LEVEL_PROBABLE);
    assign read_fields_clear = (m_alarm_level == LEVEL_PROBABLE) &&
                               (m_side_code == SIDE_NONE) && !m_probable_mark;

    `CPC_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `CPC_ASSERT(a_hold, aclk, aresetn, stall_out |=> m_valid && $stable(m_payload), "result moved")

    `CPC_ASSERT(a_read_clean, aclk, aresetn, read_out |-> read_fields_clear, "alarm fields in read")

    `CPC_ASSERT(a_alarm_clean, aclk, aresetn, alarm_out |-> m_read_value == '0, "data in alarm")

    `CPC_ASSERT(a_prob_mark, aclk, aresetn, prob_out |-> m_probable_mark, "probable without mark")

endmodule

bind crash_peak_classifier cpc_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cpc_checker (.*);
